>>> rtl/core/sbt_pkg.sv
package sbt_pkg;

  // character codes
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLsq    = 8'h5B;
  localparam logic [7:0] ChRsq    = 8'h5D;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;

  // result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // most results one source byte can cause
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [CntW-1:0]          cnt;
  } bundle_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b == ChLf) || (b == ChCr) || (b == ChTab);
  endfunction

  function automatic logic bracket_char(input logic [7:0] b);
    return (b == ChLparen) || (b == ChRparen) || (b == ChLsq) || (b == ChRsq) ||
           (b == ChLbrace) || (b == ChRbrace);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == ChN) r = ChLf;
    else if (b == ChR) r = ChCr;
    else if (b == ChT) r = ChTab;
    else if (b == ChZero) r = 8'h00;
    return r;
  endfunction

endpackage

>>> rtl/core/sexpr_byte_tokenizer.sv
// data path: an accepted byte is held in the input request register, and its decoded
// results are loaded into the output register and offered from there one at a time
// throughput: one byte per cycle while each byte causes at most one result and the
// output is ready; a byte with several results holds the single output register until
// all are taken (brackets after an open token cause three), bytes with none retire at once
// reset: comment, string, escape, quote and open-token flags clear, no request held
module sexpr_byte_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic             bundle_valid;
  logic             bundle_ready;
  sbt_pkg::bundle_t bundle;

  // byte decode and tokenizer state
  sbt_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .bundle_valid_o (bundle_valid),
    .bundle_ready_i (bundle_ready),
    .bundle_o       (bundle)
  );

  // one result per cycle to the output while the output is ready
  sbt_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_ready_o (bundle_ready),
    .bundle_i       (bundle),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

endmodule

>>> rtl/core/sbt_decode.sv
module sbt_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  output logic             bundle_valid_o,
  input  logic             bundle_ready_i,
  output sbt_pkg::bundle_t bundle_o
);

  logic       s1_valid_q;
  logic [7:0] byte_q;
  logic       comment_q, comment_d;
  logic       string_q, string_d;
  logic       esc_q, esc_d;
  logic       single_q, single_d;
  logic       open_q, open_d;
  logic       advance;
  logic [7:0] close_quote;
  sbt_pkg::bundle_t bnd;

  // token decode of the held byte
  always_comb begin
    comment_d   = comment_q;
    string_d    = string_q;
    esc_d       = esc_q;
    single_d    = single_q;
    open_d      = open_q;
    bnd         = '0;
    close_quote = single_q ? sbt_pkg::ChSquote : sbt_pkg::ChDquote;
    priority if (comment_q) begin
      if (byte_q == sbt_pkg::ChLf) comment_d = 1'b0;
    end else if (string_q) begin
      priority if (esc_q) begin
        bnd.res[0] = '{kind: sbt_pkg::KindChar, data: sbt_pkg::unescape(byte_q)};
        bnd.cnt    = sbt_pkg::CntW'(1);
        esc_d      = 1'b0;
        open_d     = 1'b1;
      end else if (byte_q == sbt_pkg::ChBslash) begin
        esc_d = 1'b1;
      end else if (byte_q == close_quote) begin
        bnd.res[0] = '{kind: sbt_pkg::KindChar, data: byte_q};
        bnd.res[1] = '{kind: sbt_pkg::KindEnd, data: 8'h00};
        bnd.cnt    = sbt_pkg::CntW'(2);
        string_d   = 1'b0;
        open_d     = 1'b0;
      end else begin
        bnd.res[0] = '{kind: sbt_pkg::KindChar, data: byte_q};
        bnd.cnt    = sbt_pkg::CntW'(1);
        open_d     = 1'b1;
      end
    end else if (byte_q == sbt_pkg::ChSemi) begin
      comment_d = 1'b1;
    end else if (byte_q == sbt_pkg::ChDquote || byte_q == sbt_pkg::ChSquote) begin
      bnd.res[0] = '{kind: sbt_pkg::KindChar, data: byte_q};
      bnd.cnt    = sbt_pkg::CntW'(1);
      string_d   = 1'b1;
      esc_d      = 1'b0;
      single_d   = (byte_q == sbt_pkg::ChSquote);
      open_d     = 1'b1;
    end else if (sbt_pkg::is_blank(byte_q)) begin
      if (open_q) begin
        bnd.res[0] = '{kind: sbt_pkg::KindEnd, data: 8'h00};
        bnd.cnt    = sbt_pkg::CntW'(1);
      end
      open_d = 1'b0;
    end else if (sbt_pkg::bracket_char(byte_q)) begin
      if (open_q) begin
        bnd.res[0] = '{kind: sbt_pkg::KindEnd, data: 8'h00};
        bnd.res[1] = '{kind: sbt_pkg::KindChar, data: byte_q};
        bnd.res[2] = '{kind: sbt_pkg::KindEnd, data: 8'h00};
        bnd.cnt    = sbt_pkg::CntW'(3);
      end else begin
        bnd.res[0] = '{kind: sbt_pkg::KindChar, data: byte_q};
        bnd.res[1] = '{kind: sbt_pkg::KindEnd, data: 8'h00};
        bnd.cnt    = sbt_pkg::CntW'(2);
      end
      open_d = 1'b0;
    end else begin
      bnd.res[0] = '{kind: sbt_pkg::KindChar, data: byte_q};
      bnd.cnt    = sbt_pkg::CntW'(1);
      open_d     = 1'b1;
    end
  end

  // a byte with no results retires without waiting on the emitter
  assign bundle_valid_o = s1_valid_q && (bnd.cnt != '0);
  assign bundle_o       = bnd;
  assign advance        = s1_valid_q && ((bnd.cnt == '0) || bundle_ready_i);
  assign in_ready_o     = !s1_valid_q || advance;

  // input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  // tokenizer state, committed when the byte retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q <= 1'b0;
      string_q  <= 1'b0;
      esc_q     <= 1'b0;
      single_q  <= 1'b0;
      open_q    <= 1'b0;
    end else if (advance) begin
      comment_q <= comment_d;
      string_q  <= string_d;
      esc_q     <= esc_d;
      single_q  <= single_d;
      open_q    <= open_d;
    end
  end

  // an escape is only pending inside a string
  a_esc_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> string_q)
    else $error("escape pending outside a string");

  // comment and string modes never overlap
  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(comment_q && string_q))
    else $error("comment and string mode both set");

  // a held byte that waits keeps the state untouched
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> ($stable(open_q) && $stable(string_q) &&
                                  $stable(comment_q)))
    else $error("tokenizer state changed while byte stalled");

endmodule

>>> rtl/core/sbt_emit.sv
module sbt_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             bundle_valid_i,
  output logic             bundle_ready_o,
  input  sbt_pkg::bundle_t bundle_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  logic                     valid_q;
  logic [sbt_pkg::IdxW-1:0] idx_q;
  sbt_pkg::bundle_t         bundle_q;
  sbt_pkg::result_t         cur;
  logic                     fire;
  logic                     done;
  logic                     load;

  // current result of the held bundle
  assign cur         = bundle_q.res[idx_q];
  assign out_valid_o = valid_q;
  assign kind_o      = cur.kind;
  assign out_byte_o  = cur.data;
  assign last_o      = (sbt_pkg::CntW'(idx_q) == (bundle_q.cnt - sbt_pkg::CntW'(1)));

  assign fire           = valid_q && out_ready_i;
  assign done           = fire && last_o;
  assign bundle_ready_o = !valid_q || done;
  assign load           = bundle_valid_i && bundle_ready_o;

  // result sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + sbt_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bundle_q <= bundle_i;
    end
  end

  // the index stays inside the held bundle
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((sbt_pkg::CntW'(idx_q) < bundle_q.cnt) && (bundle_q.cnt != '0)))
    else $error("result index beyond bundle");

  // a token end carries a zero byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_o == sbt_pkg::KindEnd) |-> (out_byte_o == 8'h00))
    else $error("token end with nonzero byte");

  // a non-final result taken moves to the next slot of the same bundle
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_o) |=> (valid_q && idx_q == $past(idx_q) + sbt_pkg::IdxW'(1)))
    else $error("result sequence skipped or lost");

endmodule
